/* rtl/espl_pkg.sv */
// shared types, codes and helpers for the encoder speed/position loop
// no dependencies; imported by every module of the block
`default_nettype none

package espl_pkg;

    // width of the position and target counters
    localparam int POS_WIDTH  = 32;
    localparam int OUT_WIDTH  = 32;
    localparam int SPEED_W    = 16;
    localparam int GAIN_W     = 8;
    localparam int MAXSPD_W   = 15;
    localparam int PERIOD_W   = 16;
    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INVERTED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS = 2'd3;

    // reset values of the configuration registers
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 8'd1;
    localparam logic [MAXSPD_W-1:0] MAXSPD_RST = 15'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd50;

    typedef enum logic [1:0] {
        FUNC_ENC_EDGE = 2'd0,
        FUNC_TICK     = 2'd1,
        FUNC_SET_SPD  = 2'd2,
        FUNC_CLEAR    = 2'd3
    } espl_func_t;

    typedef struct packed {
        espl_func_t                func;
        logic                      enc_b_level;
        logic signed [SPEED_W-1:0] speed_cmd;
    } espl_in_t;

    typedef struct packed {
        logic                        backward;
        logic [DUTY_W-1:0]           duty;
        logic signed [OUT_WIDTH-1:0] position_now;
        logic signed [OUT_WIDTH-1:0] target_now;
    } espl_out_t;

    typedef struct packed {
        logic              backward;
        logic [DUTY_W-1:0] duty;
    } espl_drive_t;

    // sign-extend or truncate a position value to the output width
    function automatic logic signed [OUT_WIDTH-1:0] pos_to_out(
        input logic [POS_WIDTH-1:0] v
    );
        logic [POS_WIDTH+OUT_WIDTH-1:0] ext;
        begin
            ext = {{OUT_WIDTH{v[POS_WIDTH-1]}}, v};
            return ext[OUT_WIDTH-1:0];
        end
    endfunction

    // sign-extend a speed to the position width
    function automatic logic [POS_WIDTH-1:0] speed_to_pos(
        input logic signed [SPEED_W-1:0] s
    );
        logic [POS_WIDTH+SPEED_W-1:0] ext;
        begin
            ext = {{POS_WIDTH{s[SPEED_W-1]}}, s};
            return ext[POS_WIDTH-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/encoder_speed_position_loop_core.sv */
// top level of the encoder speed/position loop: input register, state update,
// result register; depends on espl_pkg and espl_drive
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  in       | in        | in_valid / in_stall  | in_item  (espl_in_t)
//  out      | out       | out_valid / out_stall| out_item (espl_out_t)
//  cfg      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; a result is valid once its item has passed
// through the input register, then state update plus drive multiply into the result register
// rst_n clears control and the loop state and resets the configuration registers
// out_stall holds the result register; a full input register then also stalls new items
// cfg writes are always taken and must come only while the block is idle
`default_nettype none

module encoder_speed_position_loop_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire espl_pkg::espl_in_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output espl_pkg::espl_out_t                  out_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [espl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [espl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import espl_pkg::*;

    logic                       in_valid_reg;
    espl_in_t                   in_item_reg;
    logic                       out_valid_reg;
    espl_out_t                  out_item_reg;

    logic                       inverted_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic [MAXSPD_W-1:0]        max_speed_reg;
    logic [PERIOD_W-1:0]        period_ticks_reg;

    logic [POS_WIDTH-1:0]       pos_reg, pos_next;
    logic [POS_WIDTH-1:0]       target_reg, target_next;
    logic signed [SPEED_W-1:0]  speed_reg, speed_next;
    logic [PERIOD_W-1:0]        period_cnt_reg, period_cnt_next;

    logic                       advance;
    logic                       do_item;
    logic signed [SPEED_W-1:0]  lim;
    espl_drive_t                drive;

    assign advance   = !out_valid_reg || !out_stall;
    assign do_item   = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverted_reg     <= 1'b0;
            gain_reg         <= GAIN_RST;
            max_speed_reg    <= MAXSPD_RST;
            period_ticks_reg <= PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INVERTED:     inverted_reg     <= cfg_data[0];
                CFG_GAIN:         gain_reg         <= cfg_data[GAIN_W-1:0];
                CFG_MAX_SPEED:    max_speed_reg    <= cfg_data[MAXSPD_W-1:0];
                CFG_PERIOD_TICKS: period_ticks_reg <= cfg_data[PERIOD_W-1:0];
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
    end

    // state update for the item in the input register
    always_comb
    begin
        pos_next        = pos_reg;
        target_next     = target_reg;
        speed_next      = speed_reg;
        period_cnt_next = period_cnt_reg;
        lim             = signed'({1'b0, max_speed_reg});
        case (in_item_reg.func)
            FUNC_ENC_EDGE:
            begin
                if (in_item_reg.enc_b_level ^ inverted_reg)
                    pos_next = pos_reg + 1'b1;
                else
                    pos_next = pos_reg - 1'b1;
            end
            FUNC_TICK:
            begin
                if (period_cnt_reg >= period_ticks_reg)
                begin
                    target_next     = target_reg + speed_to_pos(speed_reg);
                    period_cnt_next = '0;
                end
                else
                    period_cnt_next = period_cnt_reg + 1'b1;
            end
            FUNC_SET_SPD:
            begin
                if (in_item_reg.speed_cmd > lim)
                    speed_next = lim;
                else if (in_item_reg.speed_cmd < -lim)
                    speed_next = -lim;
                else
                    speed_next = in_item_reg.speed_cmd;
            end
            FUNC_CLEAR:
            begin
                pos_next        = '0;
                target_next     = '0;
                speed_next      = '0;
                period_cnt_next = '0;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            target_reg     <= '0;
            speed_reg      <= '0;
            period_cnt_reg <= '0;
        end
        else if (do_item)
        begin
            pos_reg        <= pos_next;
            target_reg     <= target_next;
            speed_reg      <= speed_next;
            period_cnt_reg <= period_cnt_next;
        end
    end

    espl_drive u_drive (
        .position (pos_next),
        .target   (target_next),
        .gain     (gain_reg),
        .inverted (inverted_reg),
        .drive    (drive)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (do_item)
        begin
            out_item_reg.backward     <= drive.backward;
            out_item_reg.duty         <= drive.duty;
            out_item_reg.position_now <= pos_to_out(pos_next);
            out_item_reg.target_now   <= pos_to_out(target_next);
        end
    end

endmodule

`default_nettype wire

/* rtl/espl_drive.sv */
// proportional drive: error, gain multiply, saturation to pwm duty and direction
// depends on espl_pkg
`default_nettype none

module espl_drive (
    input  wire logic [espl_pkg::POS_WIDTH-1:0] position,
    input  wire logic [espl_pkg::POS_WIDTH-1:0] target,
    input  wire logic [espl_pkg::GAIN_W-1:0]    gain,
    input  wire logic                           inverted,
    output espl_pkg::espl_drive_t               drive
);
    import espl_pkg::*;

    logic [POS_WIDTH-1:0]          err;
    logic [POS_WIDTH-1:0]          mag;
    logic                          neg;
    logic                          big;
    logic [DUTY_W+GAIN_W-1:0]      prod;

    always_comb
    begin
        err  = target - position;
        neg  = err[POS_WIDTH-1];
        mag  = neg ? (~err + 1'b1) : err;
        // anything at or above 256 saturates for any nonzero gain
        big  = |mag[POS_WIDTH-1:DUTY_W];
        prod = mag[DUTY_W-1:0] * gain;

        drive.backward = (neg && (gain != '0)) ^ inverted;
        if (gain == '0)
            drive.duty = '0;
        else if (big || (|prod[DUTY_W+GAIN_W-1:DUTY_W]))
            drive.duty = DUTY_MAX;
        else
            drive.duty = prod[DUTY_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/espl_checker.sv */
// port-level checks for the encoder speed/position loop, bound to the top level
// depends on espl_pkg and encoder_speed_position_loop_core
`default_nettype none

module espl_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire espl_pkg::espl_out_t             out_item
);
    import espl_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // input only stalls when the result register is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // an accepted item is in the result register after the next unblocked edge
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
        else $error("item lost in pipeline");

    // zero error gives zero duty
    a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.position_now == out_item.target_now)
            |-> out_item.duty == '0)
        else $error("nonzero duty with zero position error");

endmodule

bind encoder_speed_position_loop_core espl_checker u_espl_checker (.*);

`default_nettype wire
